@@ hdl/syscall_signature_automaton_assert.svh @@
// assertion macros shared by the block's modules
`ifndef SYSCALL_SIGNATURE_AUTOMATON_ASSERT_SVH
`define SYSCALL_SIGNATURE_AUTOMATON_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ssa_pkg.sv @@
// ----------------------------------------------------------------------------
// ssa_pkg
// types, codes and default sizes of the signature chain matcher
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int CALL_IDS_DEF     = 512;
    localparam int STATE_COUNT_DEF  = 1024;
    localparam int MAX_BRANCHES_DEF = 16;
    localparam int COUNT_BITS_DEF   = 16;

    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_TOTAL = 3'd1,
        CMD_MARK  = 3'd2,
        CMD_EVENT = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic [8:0] call_id;
        logic [3:0] branch_slot;
        logic [9:0] target_state;
        logic [4:0] branch_total;
        logic       end_mark;
    } t_in;

    typedef struct packed {
        logic [9:0] advanced_state;
        logic       no_match;
        logic       hit_end;
        logic       any_end_seen;
        logic       last;
    } t_out;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOAD,
        ST_CLR,
        ST_TOT_RD,
        ST_TOT_LAT,
        ST_BR_RD,
        ST_BR_CHK,
        ST_PRED,
        ST_INC,
        ST_DEC_RD,
        ST_DEC_WR,
        ST_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic ld_write;
        logic sweep;
        logic init;
        logic lim_load;
        logic idx_inc;
        logic br_chk;
        logic rd_pred;
        logic rd_dj;
        logic inc;
        logic dec_wr;
        logic fin;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic id_ok;
        logic idx_lt_lim;
        logic tgt_ok;
        logic pred_zero;
        logic end_flag;
        logic dj_ge2;
        logic pend_v;
        logic out_free;
    } t_sts;

endpackage

@@ hdl/ssa_ram.sv @@
// ----------------------------------------------------------------------------
// ssa_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ssa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssa_ctrl
// sequencer: init sweep, commands, branch walk and counter decrement run
// ----------------------------------------------------------------------------
`include "syscall_signature_automaton_assert.svh"

module ssa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [2:0]    i_cmd,
    input  ssa_pkg::t_sts i_sts,
    output logic          o_ready,
    output ssa_pkg::t_ctl o_ctl
);

    ssa_pkg::t_state r_state, n_state;
    logic            w_commit_ok;

    assign w_commit_ok = !i_sts.pend_v || i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssa_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_ctl   = '0;
        case (r_state)
            ssa_pkg::ST_INIT: begin
                o_ctl.sweep = 1'b1;
                o_ctl.init  = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ssa_pkg::ST_IDLE;
                end
            end
            ssa_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.latch = 1'b1;
                    case (i_cmd) inside
                        ssa_pkg::CMD_LOAD, ssa_pkg::CMD_TOTAL, ssa_pkg::CMD_MARK:
                            n_state = ssa_pkg::ST_LOAD;
                        ssa_pkg::CMD_EVENT: n_state = ssa_pkg::ST_TOT_RD;
                        ssa_pkg::CMD_CLEAR: n_state = ssa_pkg::ST_CLR;
                        default:            n_state = ssa_pkg::ST_IDLE;
                    endcase
                end
            end
            ssa_pkg::ST_LOAD: begin
                o_ctl.ld_write = 1'b1;
                n_state        = ssa_pkg::ST_IDLE;
            end
            ssa_pkg::ST_CLR: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ssa_pkg::ST_IDLE;
                end
            end
            ssa_pkg::ST_TOT_RD: begin
                n_state = i_sts.id_ok ? ssa_pkg::ST_TOT_LAT : ssa_pkg::ST_FIN;
            end
            ssa_pkg::ST_TOT_LAT: begin
                o_ctl.lim_load = 1'b1;
                n_state        = ssa_pkg::ST_BR_RD;
            end
            ssa_pkg::ST_BR_RD: begin
                n_state = i_sts.idx_lt_lim ? ssa_pkg::ST_BR_CHK : ssa_pkg::ST_FIN;
            end
            ssa_pkg::ST_BR_CHK: begin
                o_ctl.br_chk  = 1'b1;
                o_ctl.rd_pred = 1'b1;
                if (i_sts.tgt_ok) begin
                    n_state = ssa_pkg::ST_PRED;
                end else begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = ssa_pkg::ST_BR_RD;
                end
            end
            ssa_pkg::ST_PRED: begin
                if (i_sts.pred_zero) begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = ssa_pkg::ST_BR_RD;
                end else begin
                    n_state = ssa_pkg::ST_INC;
                end
            end
            ssa_pkg::ST_INC: begin
                if (w_commit_ok) begin
                    o_ctl.inc = 1'b1;
                    if (i_sts.end_flag) begin
                        n_state = ssa_pkg::ST_DEC_RD;
                    end else begin
                        o_ctl.idx_inc = 1'b1;
                        n_state       = ssa_pkg::ST_BR_RD;
                    end
                end
            end
            ssa_pkg::ST_DEC_RD: begin
                o_ctl.rd_dj = 1'b1;
                if (i_sts.dj_ge2) begin
                    n_state = ssa_pkg::ST_DEC_WR;
                end else begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = ssa_pkg::ST_BR_RD;
                end
            end
            ssa_pkg::ST_DEC_WR: begin
                o_ctl.rd_dj  = 1'b1;
                o_ctl.dec_wr = 1'b1;
                n_state      = ssa_pkg::ST_DEC_RD;
            end
            ssa_pkg::ST_FIN: begin
                if (i_sts.out_free) begin
                    o_ctl.fin = 1'b1;
                    n_state   = ssa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssa_pkg::ST_IDLE;
            end
        endcase
    end

    // a held result never outlives its event
    `SSA_ASSERT_NOW(a_idle_no_pend, i_clk, i_rst_n, r_state == ssa_pkg::ST_IDLE,
        !i_sts.pend_v, "pending result left over after event")
    // commit only when the held result has somewhere to go
    `SSA_ASSERT_NOW(a_commit_room, i_clk, i_rst_n, o_ctl.inc,
        !i_sts.pend_v || i_sts.out_free, "result committed without room")

endmodule

@@ hdl/ssa_dp.sv @@
// ----------------------------------------------------------------------------
// ssa_dp
// tables, reach counters, walk registers and result staging
// ----------------------------------------------------------------------------
`include "syscall_signature_automaton_assert.svh"

module ssa_dp #(
    parameter int CALL_IDS     = ssa_pkg::CALL_IDS_DEF,
    parameter int STATE_COUNT  = ssa_pkg::STATE_COUNT_DEF,
    parameter int MAX_BRANCHES = ssa_pkg::MAX_BRANCHES_DEF,
    parameter int COUNT_BITS   = ssa_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssa_pkg::t_in  i_data,
    input  ssa_pkg::t_ctl i_ctl,
    input  logic          i_out_ready,
    output ssa_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output ssa_pkg::t_out o_out
);

    localparam int TDEPTH = CALL_IDS * MAX_BRANCHES;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int CAW    = $clog2(CALL_IDS);
    localparam int SAW    = $clog2(STATE_COUNT);
    localparam int SWN    = (CALL_IDS > STATE_COUNT) ? CALL_IDS : STATE_COUNT;
    localparam int SWW    = $clog2(SWN);

    // latched item
    logic [2:0]     r_cmd;
    logic [8:0]     r_id;
    logic [3:0]     r_slot;
    logic [9:0]     r_tgt;
    logic [4:0]     r_tot;
    logic           r_mark;

    // walk state
    logic [4:0]     r_lim;
    logic [4:0]     r_idx;
    logic [9:0]     r_t;
    logic [SAW-1:0] r_dj;
    logic [SWW-1:0] r_sweep;
    logic           r_end_seen;

    // result staging
    logic           r_pend_v;
    ssa_pkg::t_out  r_pend;
    logic           r_out_v;
    ssa_pkg::t_out  r_out;

    logic                  w_id_ok, w_slot_ok, w_mark_ok, w_sweep_last;
    logic                  w_sw_call, w_sw_state;
    logic [TAW-1:0]        w_base;
    logic                  w_out_free;

    logic                  w_tbl_we;
    logic [TAW-1:0]        w_tbl_wa, w_tbl_ra;
    logic [9:0]            w_tbl_rd;

    logic                  w_tot_we;
    logic [CAW-1:0]        w_tot_wa;
    logic [4:0]            w_tot_wd, w_tot_rd;

    logic                  w_flg_we;
    logic [SAW-1:0]        w_flg_wa;
    logic                  w_flg_wd, w_flg_rd;

    logic                  w_cnt_we;
    logic [SAW-1:0]        w_cnt_wa, w_cnt_ra;
    logic [COUNT_BITS-1:0] w_cnt_wd, w_cnt_rd;

    assign w_id_ok    = 32'(r_id) < CALL_IDS;
    assign w_slot_ok  = 32'(r_slot) < MAX_BRANCHES;
    assign w_mark_ok  = 32'(r_tgt) < STATE_COUNT;
    assign w_sw_call  = 32'(r_sweep) < CALL_IDS;
    assign w_sw_state = 32'(r_sweep) < STATE_COUNT;
    assign w_sweep_last = i_ctl.init ? (32'(r_sweep) == SWN - 1)
                                     : (32'(r_sweep) == STATE_COUNT - 1);
    assign w_base     = TAW'(r_id) * TAW'(MAX_BRANCHES);
    assign w_out_free = !r_out_v || i_out_ready;

    // branch table, one row per call id
    assign w_tbl_we = i_ctl.ld_write && (r_cmd == ssa_pkg::CMD_LOAD) && w_id_ok && w_slot_ok;
    assign w_tbl_wa = w_base + TAW'(r_slot);
    assign w_tbl_ra = w_base + TAW'(r_idx);

    ssa_ram #(.WIDTH(10), .DEPTH(TDEPTH)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (w_tbl_we),
        .i_waddr(w_tbl_wa),
        .i_wdata(r_tgt),
        .i_raddr(w_tbl_ra),
        .o_rdata(w_tbl_rd)
    );

    // branch totals
    assign w_tot_we = (i_ctl.ld_write && (r_cmd == ssa_pkg::CMD_TOTAL) && w_id_ok)
                   || (i_ctl.sweep && i_ctl.init && w_sw_call);
    assign w_tot_wa = i_ctl.sweep ? CAW'(r_sweep) : CAW'(r_id);
    assign w_tot_wd = i_ctl.sweep ? 5'd0 : r_tot;

    ssa_ram #(.WIDTH(5), .DEPTH(CALL_IDS)) u_tot (
        .i_clk  (i_clk),
        .i_we   (w_tot_we),
        .i_waddr(w_tot_wa),
        .i_wdata(w_tot_wd),
        .i_raddr(CAW'(r_id)),
        .o_rdata(w_tot_rd)
    );

    // end marks
    assign w_flg_we = (i_ctl.ld_write && (r_cmd == ssa_pkg::CMD_MARK) && w_mark_ok)
                   || (i_ctl.sweep && i_ctl.init && w_sw_state);
    assign w_flg_wa = i_ctl.sweep ? SAW'(r_sweep) : SAW'(r_tgt);
    assign w_flg_wd = i_ctl.sweep ? 1'b0 : r_mark;

    ssa_ram #(.WIDTH(1), .DEPTH(STATE_COUNT)) u_flg (
        .i_clk  (i_clk),
        .i_we   (w_flg_we),
        .i_waddr(w_flg_wa),
        .i_wdata(w_flg_wd),
        .i_raddr(SAW'(r_t)),
        .o_rdata(w_flg_rd)
    );

    // reach counters
    always_comb begin
        w_cnt_we = 1'b0;
        w_cnt_wa = SAW'(r_t);
        w_cnt_wd = (&w_cnt_rd) ? w_cnt_rd : w_cnt_rd + 1'b1;
        if (i_ctl.sweep) begin
            w_cnt_we = w_sw_state;
            w_cnt_wa = SAW'(r_sweep);
            w_cnt_wd = (32'(r_sweep) == 1) ? COUNT_BITS'(1) : '0;
        end else if (i_ctl.dec_wr) begin
            w_cnt_we = 1'b1;
            w_cnt_wa = r_dj;
            w_cnt_wd = (w_cnt_rd == '0) ? '0 : w_cnt_rd - 1'b1;
        end else if (i_ctl.inc) begin
            w_cnt_we = 1'b1;
        end
    end

    assign w_cnt_ra = i_ctl.rd_pred ? SAW'(w_tbl_rd - 10'd1)
                    : i_ctl.rd_dj   ? r_dj
                    :                 SAW'(r_t);

    ssa_ram #(.WIDTH(COUNT_BITS), .DEPTH(STATE_COUNT)) u_cnt (
        .i_clk  (i_clk),
        .i_we   (w_cnt_we),
        .i_waddr(w_cnt_wa),
        .i_wdata(w_cnt_wd),
        .i_raddr(w_cnt_ra),
        .o_rdata(w_cnt_rd)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd  <= i_data.cmd;
            r_id   <= i_data.call_id;
            r_slot <= i_data.branch_slot;
            r_tgt  <= i_data.target_state;
            r_tot  <= i_data.branch_total;
            r_mark <= i_data.end_mark;
        end
        if (i_ctl.lim_load) begin
            r_lim <= (32'(w_tot_rd) > MAX_BRANCHES) ? 5'(MAX_BRANCHES) : w_tot_rd;
            r_idx <= 5'd0;
        end else if (i_ctl.idx_inc) begin
            r_idx <= r_idx + 5'd1;
        end
        if (i_ctl.br_chk) begin
            r_t <= w_tbl_rd;
        end
        if (i_ctl.inc) begin
            r_dj <= SAW'(r_t);
        end else if (i_ctl.dec_wr) begin
            r_dj <= r_dj - 1'b1;
        end
        if (i_ctl.inc) begin
            r_pend.advanced_state <= r_t;
            r_pend.no_match       <= 1'b0;
            r_pend.hit_end        <= w_flg_rd;
            r_pend.any_end_seen   <= r_end_seen | w_flg_rd;
            r_pend.last           <= 1'b0;
        end
        if (i_ctl.inc && r_pend_v) begin
            r_out <= r_pend;
        end else if (i_ctl.fin) begin
            if (r_pend_v) begin
                r_out.advanced_state <= r_pend.advanced_state;
                r_out.no_match       <= r_pend.no_match;
                r_out.hit_end        <= r_pend.hit_end;
                r_out.any_end_seen   <= r_pend.any_end_seen;
                r_out.last           <= 1'b1;
            end else begin
                r_out.advanced_state <= 10'd0;
                r_out.no_match       <= 1'b1;
                r_out.hit_end        <= 1'b0;
                r_out.any_end_seen   <= r_end_seen;
                r_out.last           <= 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep    <= '0;
            r_end_seen <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_ctl.sweep) begin
                r_sweep <= w_sweep_last ? '0 : r_sweep + 1'b1;
            end
            if (i_ctl.sweep && !i_ctl.init) begin
                r_end_seen <= 1'b0;
            end else if (i_ctl.inc && w_flg_rd) begin
                r_end_seen <= 1'b1;
            end
            if (i_ctl.inc) begin
                r_pend_v <= 1'b1;
            end else if (i_ctl.fin) begin
                r_pend_v <= 1'b0;
            end
            if ((i_ctl.inc && r_pend_v) || i_ctl.fin) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.sweep_last = w_sweep_last;
        o_sts.id_ok      = w_id_ok;
        o_sts.idx_lt_lim = r_idx < r_lim;
        o_sts.tgt_ok     = (w_tbl_rd != 10'd0) && (32'(w_tbl_rd) < STATE_COUNT);
        o_sts.pred_zero  = (w_cnt_rd == '0);
        o_sts.end_flag   = w_flg_rd;
        o_sts.dj_ge2     = 32'(r_dj) >= 2;
        o_sts.pend_v     = r_pend_v;
        o_sts.out_free   = w_out_free;
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // a result moved out of the holding register shows up on the output
    `SSA_ASSERT_NEXT(a_pend_moves_out, i_clk, i_rst_n, i_ctl.inc && r_pend_v,
        r_out_v, "held result dropped")
    // a stalled result stays on the output
    `SSA_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_out_v && !i_out_ready,
        r_out_v, "stalled result lost")

endmodule

@@ hdl/syscall_signature_automaton.sv @@
// ----------------------------------------------------------------------------
// syscall_signature_automaton
// matches system-call events against loaded signature chains
// ----------------------------------------------------------------------------
// usage:
//   input channel i_valid/o_ready carries one command per transfer: branch
//   entry load, branch count, end mark, event, or counter clear
//   output channel o_valid/i_ready carries results of events only: one per
//   taken branch, or a single no-match result; last marks the final one
// sequence:
//   load commands write their table entry; clear sweeps the reach counters
//   an event walks its branch slots in order; an end-state hit then walks
//   the reach counters down, each step one read then one write on the
//   single counter ram port
// reset:
//   after reset the block sweeps max(CALL_IDS, STATE_COUNT) addresses clearing
//   branch counts, end marks and reach counters; o_ready stays low meanwhile
// stall:
//   one result is held back until the next is known, so last can be set;
//   while a result is held and the output register is full the walk pauses;
//   a new command is accepted as soon as the event is finished, even with a result waiting
module syscall_signature_automaton #(
    parameter int CALL_IDS     = ssa_pkg::CALL_IDS_DEF,
    parameter int STATE_COUNT  = ssa_pkg::STATE_COUNT_DEF,
    parameter int MAX_BRANCHES = ssa_pkg::MAX_BRANCHES_DEF,
    parameter int COUNT_BITS   = ssa_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // command transfers
    input  logic          i_valid,
    output logic          o_ready,
    input  ssa_pkg::t_in  i_data,
    // result transfers
    output logic          o_valid,
    input  logic          i_ready,
    output ssa_pkg::t_out o_data
);

    // command and status between sequencer and datapath
    ssa_pkg::t_ctl w_ctl;
    ssa_pkg::t_sts w_sts;

    // sequencer: walks branches and counter runs one step at a time
    ssa_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_cmd  (i_data.cmd),
        .i_sts  (w_sts),
        .o_ready(o_ready),
        .o_ctl  (w_ctl)
    );

    // datapath: tables, counters and the two-deep result staging
    ssa_dp #(
        .CALL_IDS    (CALL_IDS),
        .STATE_COUNT (STATE_COUNT),
        .MAX_BRANCHES(MAX_BRANCHES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (i_data),
        .i_ctl      (w_ctl),
        .i_out_ready(i_ready),
        .o_sts      (w_sts),
        .o_out_valid(o_valid),
        .o_out      (o_data)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the signature chain matcher against a predictor of its counters
// ----------------------------------------------------------------------------
// commands go in one transfer at a time and every event is predicted at
// acceptance; a monitor compares each result transfer with the oldest
// prediction; phases vary sender gaps and receiver stalls, and one phase
// fans single events out to sixteen results each
module testbench;

    localparam int CALLS  = ssa_pkg::CALL_IDS_DEF;
    localparam int STATES = ssa_pkg::STATE_COUNT_DEF;
    localparam int SLOTS  = ssa_pkg::MAX_BRANCHES_DEF;
    localparam int COUNT_CEIL = (1 << ssa_pkg::COUNT_BITS_DEF) - 1;
    // unused command codes, the block must ignore them
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    // call ids whose rows are fully written, so events never read a blank slot
    localparam int POOL_SIZE = 4;
    localparam int ID_POOL [POOL_SIZE] = '{0, 1, 3, 511};
    localparam int SAT_ID = 3;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    ssa_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_ready;
    ssa_pkg::t_out o_data;

    // shadow state of the matcher
    logic [9:0] shadow_branch [CALLS*SLOTS];
    int         shadow_total  [CALLS];
    bit         shadow_end    [STATES];
    int         shadow_count  [STATES];
    bit         shadow_seen;

    ssa_pkg::t_out pending_results [$];
    int            error_count = 0;
    int            gap_pct   = 0;
    int            stall_pct = 0;

    syscall_signature_automaton DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #4 i_clk = ~i_clk;

    // receiver stalls at the current rate
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // predictor: update shadow state for one accepted command, queue results
    task automatic predict_matches(input ssa_pkg::t_in it);
        int            lim;
        int            tgt;
        int            produced;
        ssa_pkg::t_out r;
        begin
            produced = 0;
            case (it.cmd)
                ssa_pkg::CMD_LOAD:
                    shadow_branch[int'(it.call_id)*SLOTS + int'(it.branch_slot)] =
                        it.target_state;
                ssa_pkg::CMD_TOTAL: shadow_total[it.call_id] = int'(it.branch_total);
                ssa_pkg::CMD_MARK: shadow_end[it.target_state] = it.end_mark;
                ssa_pkg::CMD_CLEAR: begin
                    foreach (shadow_count[s]) shadow_count[s] = 0;
                    shadow_count[1] = 1;
                    shadow_seen = 1'b0;
                end
                ssa_pkg::CMD_EVENT: begin
                    lim = (shadow_total[it.call_id] > SLOTS) ? SLOTS
                                                             : shadow_total[it.call_id];
                    for (int i = 0; i < lim; i++) begin
                        tgt = int'(shadow_branch[int'(it.call_id)*SLOTS + i]);
                        // empty slot, or predecessor never reached
                        if (tgt == 0 || shadow_count[tgt-1] == 0) continue;
                        if (shadow_count[tgt] < COUNT_CEIL) shadow_count[tgt]++;
                        if (shadow_end[tgt]) begin
                            shadow_seen = 1'b1;
                            // walk the chain back down, floors at zero
                            for (int s = tgt; s > 1; s--)
                                if (shadow_count[s] > 0) shadow_count[s]--;
                        end
                        r.advanced_state = tgt[9:0];
                        r.no_match       = 1'b0;
                        r.hit_end        = shadow_end[tgt];
                        r.any_end_seen   = shadow_seen;
                        r.last           = 1'b0;
                        pending_results.push_back(r);
                        produced++;
                    end
                    if (produced == 0) begin
                        r = '0;
                        r.no_match     = 1'b1;
                        r.any_end_seen = shadow_seen;
                        pending_results.push_back(r);
                    end
                    pending_results[$].last = 1'b1;
                end
                default: ;
            endcase
        end
    endtask

    // result transfer check against oldest prediction
    always @(posedge i_clk) begin
        ssa_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %p", o_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_data.advanced_state !== want.advanced_state) begin
                    $error("advanced_state expected %0d got %0d",
                           want.advanced_state, o_data.advanced_state);
                    error_count++;
                end
                if (o_data.no_match !== want.no_match) begin
                    $error("no_match expected %0b got %0b", want.no_match, o_data.no_match);
                    error_count++;
                end
                if (o_data.hit_end !== want.hit_end) begin
                    $error("hit_end expected %0b got %0b", want.hit_end, o_data.hit_end);
                    error_count++;
                end
                if (o_data.any_end_seen !== want.any_end_seen) begin
                    $error("any_end_seen expected %0b got %0b",
                           want.any_end_seen, o_data.any_end_seen);
                    error_count++;
                end
                if (o_data.last !== want.last) begin
                    $error("last expected %0b got %0b", want.last, o_data.last);
                    error_count++;
                end
            end
        end
    end

    // one command transfer; valid stays high across back-to-back items
    task automatic send_command(input ssa_pkg::t_in it);
        int gap;
        begin
            gap = ($urandom_range(99) < gap_pct) ? int'($urandom_range(6, 1)) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data  <= it;
            do @(posedge i_clk); while (!o_ready);
            predict_matches(it);
        end
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off until every predicted result has arrived
    task automatic drain_results();
        drop_valid();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic ssa_pkg::t_in make_cmd(input logic [2:0] c, input int id,
                                              input int slot, input int tgt,
                                              input int tot, input int mark);
        ssa_pkg::t_in it;
        it.cmd          = c;
        it.call_id      = id[8:0];
        it.branch_slot  = slot[3:0];
        it.target_state = tgt[9:0];
        it.branch_total = tot[4:0];
        it.end_mark     = mark[0];
        return it;
    endfunction

    // small targets so chains actually form
    function automatic int pick_target();
        return ($urandom_range(9) < 7) ? int'($urandom_range(12))
                                       : int'($urandom_range(STATES - 1));
    endfunction

    task automatic test_table_setup();
        // every slot of the pool rows gets a defined target
        for (int p = 0; p < POOL_SIZE; p++)
            for (int s = 0; s < SLOTS; s++)
                send_command(make_cmd(ssa_pkg::CMD_LOAD, ID_POOL[p], s, 0, 0, 0));
    endtask

    task automatic test_directed();
        // chain 1 -> 2 -> 3 with 3 an end state, both taken in one event
        send_command(make_cmd(ssa_pkg::CMD_LOAD, 0, 0, 2, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_LOAD, 0, 1, 3, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_TOTAL, 0, 0, 0, 16, 0));
        send_command(make_cmd(ssa_pkg::CMD_MARK, 0, 0, 3, 0, 1));
        send_command(make_cmd(ssa_pkg::CMD_EVENT, 0, 0, 0, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_EVENT, 0, 0, 0, 0, 0));
        // zero branch count gives no-match
        send_command(make_cmd(ssa_pkg::CMD_EVENT, 1, 15, 1023, 0, 1));
        // oversized count is clamped, top state and top id
        send_command(make_cmd(ssa_pkg::CMD_LOAD, 511, 15, 1023, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_LOAD, 511, 14, 1022, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_TOTAL, 511, 0, 0, 31, 0));
        send_command(make_cmd(ssa_pkg::CMD_MARK, 0, 0, 1023, 0, 1));
        send_command(make_cmd(ssa_pkg::CMD_EVENT, 511, 0, 0, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_MARK, 0, 0, 1023, 0, 0));
        // spare commands change nothing
        for (logic [2:0] c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST && c != 3'd0; c++)
            send_command(make_cmd(c, 511, 15, 1023, 31, 1));
        send_command(make_cmd(ssa_pkg::CMD_EVENT, 0, 0, 0, 0, 0));
        // clear drops counters and the sticky flag, tables survive
        send_command(make_cmd(ssa_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_EVENT, 0, 0, 0, 0, 0));
        drain_results();
    endtask

    task automatic test_random(input int gaps, input int stalls, input int count);
        int           pick;
        ssa_pkg::t_in it;
        begin
            gap_pct   = gaps;
            stall_pct = stalls;
            for (int n = 0; n < count; n++) begin
                pick = int'($urandom_range(99));
                it = ssa_pkg::t_in'($urandom);
                if (pick < 58) begin
                    it.cmd     = ssa_pkg::CMD_EVENT;
                    it.call_id = 9'(ID_POOL[$urandom_range(POOL_SIZE - 1)]);
                end else if (pick < 74) begin
                    it.cmd = ssa_pkg::CMD_LOAD;
                    // rows outside the pool keep count zero, so writes there are harmless
                    if ($urandom_range(3) != 0)
                        it.call_id = 9'(ID_POOL[$urandom_range(POOL_SIZE - 1)]);
                    it.target_state = 10'(pick_target());
                end else if (pick < 82) begin
                    it.cmd          = ssa_pkg::CMD_TOTAL;
                    it.call_id      = 9'(ID_POOL[$urandom_range(POOL_SIZE - 1)]);
                    it.branch_total = 5'($urandom_range(31));
                end else if (pick < 93) begin
                    it.cmd          = ssa_pkg::CMD_MARK;
                    it.target_state = 10'(pick_target());
                end else if (pick < 96) begin
                    it.cmd = ssa_pkg::CMD_CLEAR;
                end else begin
                    it.cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
                end
                send_command(it);
                if (n == count / 2) drain_results();
            end
            drain_results();
        end
    endtask

    task automatic test_fanout();
        gap_pct   = 0;
        stall_pct = 0;
        send_command(make_cmd(ssa_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_MARK, 0, 0, 2, 0, 0));
        for (int s = 0; s < SLOTS; s++)
            send_command(make_cmd(ssa_pkg::CMD_LOAD, SAT_ID, s, 2, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_TOTAL, SAT_ID, 0, 0, 16, 0));
        // sixteen increments of state two per event
        repeat (4) send_command(make_cmd(ssa_pkg::CMD_EVENT, SAT_ID, 0, 0, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_MARK, 0, 0, 2, 0, 1));
        send_command(make_cmd(ssa_pkg::CMD_EVENT, SAT_ID, 0, 0, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_MARK, 0, 0, 2, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_TOTAL, SAT_ID, 0, 0, 0, 0));
        send_command(make_cmd(ssa_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
        drain_results();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        i_ready <= 1'b0;
        foreach (shadow_branch[k]) shadow_branch[k] = '0;
        foreach (shadow_total[k])  shadow_total[k]  = 0;
        foreach (shadow_end[k])    shadow_end[k]    = 1'b0;
        foreach (shadow_count[k])  shadow_count[k]  = 0;
        shadow_count[1] = 1;
        shadow_seen     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_setup();
        test_directed();
        test_random(0, 0, 38);
        test_random(74, 0, 38);
        test_random(0, 74, 38);
        test_random(24, 24, 38);
        test_fanout();

        // let a trailing clear or walk finish, then look for strays
        repeat (STATES + 64) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ssa_pkg.sv
hdl/ssa_ram.sv
hdl/ssa_ctrl.sv
hdl/ssa_dp.sv
hdl/syscall_signature_automaton.sv
tb/sv/testbench.sv
